// File: rtl/bth_pkg.sv
// Boundary-tag heap allocator: shared types, codes and layout constants.
// No dependencies; used by the top level and the port checker.
package bth_pkg;

    localparam int HEAP_BYTES_DEFAULT = 65536;
    localparam int BA_W = 17;

    localparam int MIN_BLOCK   = 16;
    localparam int PROLOGUE_BP = 8;
    localparam int FIRST_BP    = 24;
    localparam int INIT_CHUNK  = 4096;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOSPACE = 2'd1;
    localparam status_t ST_ZERO    = 2'd2;

endpackage

// File: rtl/bth_ram.sv
// Heap word store: one write port, one read port with registered read data.
// No dependencies.
module bth_ram #(
    parameter int AW = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator, next-fit over a word RAM; uses bth_pkg and bth_ram.
// Allocate: zero size goes straight to the result; else check headers forward from the rover,
// then from the heap start to the rover, then grow the heap (or no space), then place the block.
// Free: check headers from the first block; a live match is tagged free and merged with free neighbours.
// One item at a time; the next is taken the cycle after the result is loaded.
// Reset: writes prologue, first free chunk and epilogue; in_ready low.
module boundary_tag_heap_allocator #(
    parameter int HEAP_BYTES = bth_pkg::HEAP_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [15:0] request_size,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] payload_address,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] growth_chunk_bytes
);

    localparam int HEAP_CAP = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam int DEPTH    = HEAP_CAP / 4;
    localparam int AW       = $clog2(DEPTH);
    localparam int LIMIT    = HEAP_CAP / 8 + 4;
    localparam int NW       = $clog2(LIMIT + 1);
    localparam int BW       = bth_pkg::BA_W;

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_P1_ROV   = 5'd2;
    localparam logic [4:0] S_P1_CHK   = 5'd3;
    localparam logic [4:0] S_P2_START = 5'd4;
    localparam logic [4:0] S_P2_FIRST = 5'd5;
    localparam logic [4:0] S_P2_CHK   = 5'd6;
    localparam logic [4:0] S_GROW0    = 5'd7;
    localparam logic [4:0] S_GROW1    = 5'd8;
    localparam logic [4:0] S_GROW2    = 5'd9;
    localparam logic [4:0] S_M0       = 5'd10;
    localparam logic [4:0] S_M1       = 5'd11;
    localparam logic [4:0] S_M2       = 5'd12;
    localparam logic [4:0] S_M3       = 5'd13;
    localparam logic [4:0] S_M4       = 5'd14;
    localparam logic [4:0] S_PL0      = 5'd15;
    localparam logic [4:0] S_PL1      = 5'd16;
    localparam logic [4:0] S_PL2      = 5'd17;
    localparam logic [4:0] S_PL3      = 5'd18;
    localparam logic [4:0] S_F_CHK    = 5'd19;
    localparam logic [4:0] S_F_TAG0   = 5'd20;
    localparam logic [4:0] S_F_TAG1   = 5'd21;
    localparam logic [4:0] S_DONE     = 5'd22;

    localparam logic [BW-1:0] MIN_B  = BW'(bth_pkg::MIN_BLOCK);
    localparam logic [BW-1:0] PRO_BP = BW'(bth_pkg::PROLOGUE_BP);
    localparam logic [BW-1:0] FST_BP = BW'(bth_pkg::FIRST_BP);
    localparam logic [BW-1:0] INIT_C = BW'(bth_pkg::INIT_CHUNK);

    function automatic logic [31:0] tag(input logic [BW-1:0] size, input logic used);
        tag = {{(32-BW){1'b0}}, size[BW-1:3], 2'b00, used};
    endfunction

    function automatic logic [BW-1:0] tsize(input logic [31:0] word);
        tsize = {word[BW-1:3], 3'b000};
    endfunction

    logic [4:0]          state_reg, state_next;
    logic [2:0]          init_cnt_reg, init_cnt_next;
    logic [BW-1:0]       bp_reg, bp_next;
    logic [BW-1:0]       csize_reg, csize_next;
    logic [BW-1:0]       asize_reg, asize_next;
    logic [BW-1:0]       psize_reg, psize_next;
    logic                pused_reg, pused_next;
    logic                split_reg, split_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [15:0]         rover_reg, rover_next;
    logic [BW-1:0]       top_reg, top_next;
    logic [15:0]         chunk_reg, chunk_next;
    logic                cmd_reg, cmd_next;
    logic [15:0]         addr_reg, addr_next;
    logic [15:0]         res_pa_reg, res_pa_next;
    logic [1:0]          res_st_reg, res_st_next;
    logic                ov_reg, ov_next;
    logic [15:0]         pa_reg, pa_next;
    logic [1:0]          st_reg, st_next;
    logic                oob_reg;

    logic                rd_en, wr_en;
    logic [BW-1:0]       rd_addr, wr_addr;
    logic [31:0]         wr_data, ram_q, rdata;
    logic                rd_oob, wr_oob;

    logic [BW-1:0]       rsize;
    logic [BW-1:0]       ext;
    logic [BW:0]         gsize, room;
    logic [NW-1:0]       n_inc;
    logic [BW-1:0]       remain;
    logic [BW-1:0]       req_sum;
    logic [BW-1:0]       req_asize;

    assign rd_oob = rd_addr[BW-1:2] >= (BW-2)'(DEPTH);
    assign wr_oob = wr_addr[BW-1:2] >= (BW-2)'(DEPTH);

    bth_ram #(.AW(AW)) u_ram (
        .clk   (clk),
        .we    (wr_en && !wr_oob),
        .waddr (wr_addr[AW+1:2]),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr[AW+1:2]),
        .rdata (ram_q)
    );

    assign rdata  = oob_reg ? 32'd0 : ram_q;
    assign rsize  = tsize(rdata);
    assign n_inc  = n_reg + NW'(1);
    assign remain = csize_reg - asize_reg;
    assign ext    = (asize_reg > {1'b0, chunk_reg}) ? asize_reg : {1'b0, chunk_reg};
    assign gsize  = {(({1'b0, ext[BW-1:2]} + (BW-1)'(1)) & ~(BW-1)'(1)), 2'b00};
    assign room   = (BW+1)'(HEAP_CAP) - {1'b0, top_reg};
    assign req_sum   = {1'b0, request_size} + BW'(15);
    assign req_asize = (request_size <= 16'd8) ? MIN_B : {req_sum[BW-1:3], 3'b000};

    assign in_ready        = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = ov_reg;
    assign payload_address = pa_reg;
    assign status          = st_reg;

    always_comb
    begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        bp_next       = bp_reg;
        csize_next    = csize_reg;
        asize_next    = asize_reg;
        psize_next    = psize_reg;
        pused_next    = pused_reg;
        split_next    = split_reg;
        n_next        = n_reg;
        rover_next    = rover_reg;
        top_next      = top_reg;
        chunk_next    = chunk_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        res_pa_next   = res_pa_reg;
        res_st_next   = res_st_reg;
        ov_next       = ov_reg;
        pa_next       = pa_reg;
        st_next       = st_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        if (cfg_valid)
        begin
            chunk_next = growth_chunk_bytes;
        end
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                wr_en         = 1'b1;
                init_cnt_next = init_cnt_reg + 3'd1;
                case (init_cnt_reg)
                    3'd0:
                    begin
                        wr_addr = PRO_BP - BW'(4);
                        wr_data = tag(MIN_B, 1'b1);
                    end
                    3'd1:
                    begin
                        wr_addr = PRO_BP + MIN_B - BW'(8);
                        wr_data = tag(MIN_B, 1'b1);
                    end
                    3'd2:
                    begin
                        wr_addr = FST_BP - BW'(4);
                        wr_data = tag(INIT_C, 1'b0);
                    end
                    3'd3:
                    begin
                        wr_addr = FST_BP + INIT_C - BW'(8);
                        wr_data = tag(INIT_C, 1'b0);
                    end
                    default:
                    begin
                        wr_addr    = FST_BP + INIT_C - BW'(4);
                        wr_data    = 32'd1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    addr_next  = block_address;
                    asize_next = req_asize;
                    n_next     = '0;
                    if (command == bth_pkg::CMD_FREE)
                    begin
                        bp_next    = FST_BP;
                        rd_en      = 1'b1;
                        rd_addr    = FST_BP - BW'(4);
                        state_next = S_F_CHK;
                    end
                    else if (request_size == 16'd0)
                    begin
                        res_pa_next = '0;
                        res_st_next = bth_pkg::ST_ZERO;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = {1'b0, rover_reg} - BW'(4);
                        state_next = S_P1_ROV;
                    end
                end
            end

            S_P1_ROV:
            begin
                bp_next    = {1'b0, rover_reg} + rsize;
                rd_en      = 1'b1;
                rd_addr    = {1'b0, rover_reg} + rsize - BW'(4);
                state_next = S_P1_CHK;
            end

            S_P1_CHK:
            begin
                if (rsize == '0 || n_reg >= NW'(LIMIT))
                begin
                    state_next = S_P2_START;
                end
                else if (!rdata[0] && asize_reg <= rsize)
                begin
                    rover_next = bp_reg[15:0];
                    csize_next = rsize;
                    state_next = S_PL0;
                end
                else
                begin
                    bp_next = bp_reg + rsize;
                    n_next  = n_inc;
                    rd_en   = 1'b1;
                    rd_addr = bp_reg + rsize - BW'(4);
                end
            end

            S_P2_START:
            begin
                bp_next = PRO_BP;
                n_next  = '0;
                if (PRO_BP < {1'b0, rover_reg})
                begin
                    rd_en      = 1'b1;
                    rd_addr    = PRO_BP - BW'(4);
                    state_next = S_P2_FIRST;
                end
                else
                begin
                    state_next = S_GROW0;
                end
            end

            S_P2_FIRST:
            begin
                bp_next    = bp_reg + rsize;
                rd_en      = 1'b1;
                rd_addr    = bp_reg + rsize - BW'(4);
                state_next = S_P2_CHK;
            end

            S_P2_CHK:
            begin
                if (!rdata[0] && asize_reg <= rsize)
                begin
                    rover_next = bp_reg[15:0];
                    csize_next = rsize;
                    state_next = S_PL0;
                end
                else if (bp_reg < {1'b0, rover_reg} && n_inc < NW'(LIMIT))
                begin
                    n_next  = n_inc;
                    bp_next = bp_reg + rsize;
                    rd_en   = 1'b1;
                    rd_addr = bp_reg + rsize - BW'(4);
                end
                else
                begin
                    state_next = S_GROW0;
                end
            end

            S_GROW0:
            begin
                if (gsize > room)
                begin
                    res_pa_next = '0;
                    res_st_next = bth_pkg::ST_NOSPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = top_reg - BW'(4);
                    wr_data    = tag(gsize[BW-1:0], 1'b0);
                    bp_next    = top_reg;
                    csize_next = gsize[BW-1:0];
                    state_next = S_GROW1;
                end
            end

            S_GROW1:
            begin
                wr_en      = 1'b1;
                wr_addr    = bp_reg + csize_reg - BW'(8);
                wr_data    = tag(csize_reg, 1'b0);
                state_next = S_GROW2;
            end

            S_GROW2:
            begin
                wr_en      = 1'b1;
                wr_addr    = bp_reg + csize_reg - BW'(4);
                wr_data    = 32'd1;
                top_next   = top_reg + csize_reg;
                state_next = S_M0;
            end

            S_M0:
            begin
                rd_en      = 1'b1;
                rd_addr    = bp_reg - BW'(8);
                state_next = S_M1;
            end

            S_M1:
            begin
                pused_next = rdata[0];
                psize_next = rsize;
                rd_en      = 1'b1;
                rd_addr    = bp_reg - BW'(4);
                state_next = S_M2;
            end

            S_M2:
            begin
                csize_next = rsize;
                rd_en      = 1'b1;
                rd_addr    = bp_reg + rsize - BW'(4);
                state_next = S_M3;
            end

            S_M3:
            begin
                bp_next    = pused_reg ? bp_reg : bp_reg - psize_reg;
                csize_next = csize_reg + (pused_reg ? '0 : psize_reg)
                           + (rdata[0] ? '0 : rsize);
                wr_en      = 1'b1;
                wr_addr    = bp_next - BW'(4);
                wr_data    = tag(csize_next, 1'b0);
                rover_next = bp_next[15:0];
                state_next = S_M4;
            end

            S_M4:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + csize_reg - BW'(8);
                wr_data = tag(csize_reg, 1'b0);
                if (cmd_reg == bth_pkg::CMD_ALLOC)
                begin
                    state_next = S_PL0;
                end
                else
                begin
                    res_pa_next = '0;
                    res_st_next = bth_pkg::ST_OK;
                    state_next  = S_DONE;
                end
            end

            S_PL0:
            begin
                wr_en      = 1'b1;
                wr_addr    = bp_reg - BW'(4);
                split_next = remain >= MIN_B;
                wr_data    = (remain >= MIN_B) ? tag(asize_reg, 1'b1) : tag(csize_reg, 1'b1);
                state_next = S_PL1;
            end

            S_PL1:
            begin
                wr_en = 1'b1;
                if (split_reg)
                begin
                    wr_addr    = bp_reg + asize_reg - BW'(8);
                    wr_data    = tag(asize_reg, 1'b1);
                    state_next = S_PL2;
                end
                else
                begin
                    wr_addr     = bp_reg + csize_reg - BW'(8);
                    wr_data     = tag(csize_reg, 1'b1);
                    res_pa_next = bp_reg[15:0];
                    res_st_next = bth_pkg::ST_OK;
                    state_next  = S_DONE;
                end
            end

            S_PL2:
            begin
                wr_en      = 1'b1;
                wr_addr    = bp_reg + asize_reg - BW'(4);
                wr_data    = tag(remain, 1'b0);
                state_next = S_PL3;
            end

            S_PL3:
            begin
                wr_en       = 1'b1;
                wr_addr     = bp_reg + csize_reg - BW'(8);
                wr_data     = tag(remain, 1'b0);
                res_pa_next = bp_reg[15:0];
                res_st_next = bth_pkg::ST_OK;
                state_next  = S_DONE;
            end

            S_F_CHK:
            begin
                if (rsize == '0 || n_reg >= NW'(LIMIT))
                begin
                    res_pa_next = '0;
                    res_st_next = bth_pkg::ST_OK;
                    state_next  = S_DONE;
                end
                else if (bp_reg == {1'b0, addr_reg})
                begin
                    csize_next  = rsize;
                    res_pa_next = '0;
                    res_st_next = bth_pkg::ST_OK;
                    state_next  = rdata[0] ? S_F_TAG0 : S_DONE;
                end
                else
                begin
                    bp_next = bp_reg + rsize;
                    n_next  = n_inc;
                    rd_en   = 1'b1;
                    rd_addr = bp_reg + rsize - BW'(4);
                end
            end

            S_F_TAG0:
            begin
                wr_en      = 1'b1;
                wr_addr    = bp_reg - BW'(4);
                wr_data    = tag(csize_reg, 1'b0);
                state_next = S_F_TAG1;
            end

            S_F_TAG1:
            begin
                wr_en      = 1'b1;
                wr_addr    = bp_reg + csize_reg - BW'(8);
                wr_data    = tag(csize_reg, 1'b0);
                state_next = S_M0;
            end

            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    pa_next    = res_pa_reg;
                    st_next    = res_st_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_cnt_reg <= '0;
            rover_reg    <= bth_pkg::FIRST_BP[15:0];
            top_reg      <= FST_BP + INIT_C;
            chunk_reg    <= bth_pkg::INIT_CHUNK[15:0];
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            rover_reg    <= rover_next;
            top_reg      <= top_next;
            chunk_reg    <= chunk_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bp_reg     <= bp_next;
        csize_reg  <= csize_next;
        asize_reg  <= asize_next;
        psize_reg  <= psize_next;
        pused_reg  <= pused_next;
        split_reg  <= split_next;
        n_reg      <= n_next;
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        res_pa_reg <= res_pa_next;
        res_st_reg <= res_st_next;
        pa_reg     <= pa_next;
        st_reg     <= st_next;
        if (rd_en)
        begin
            oob_reg <= rd_oob;
        end
    end

endmodule

// File: rtl/bth_port_check.sv
// Port-level checks for the heap allocator, bound to the top level.
// Depends on bth_pkg and boundary_tag_heap_allocator.
module bth_port_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] payload_address,
    input logic [1:0]  status
);

    // items taken and not yet answered
    logic [1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == bth_pkg::ST_OK || status == bth_pkg::ST_NOSPACE
                       || status == bth_pkg::ST_ZERO))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != bth_pkg::ST_OK) |-> payload_address == 16'd0)
        else $error("failed item carries an address");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is at work");

    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(payload_address)
                                       && $stable(status)))
        else $error("result dropped while stalled");

endmodule

bind boundary_tag_heap_allocator bth_port_check u_bth_port_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .payload_address (payload_address),
    .status          (status)
);
